### rtl/wma_pkg.sv
package wma_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int WL_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [MODE_W-1:0] MODE_RECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRI  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

  localparam logic [WL_W-1:0] WL_RESET = 7'd8;

  typedef struct packed {
    logic load_sample;
    logic fill_write;
    logic fill_done;
    logic norm_write;
    logic walk_issue;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic walk_last;
    logic pipe_busy;
    logic div_done;
    logic pass;
  } status_t;

endpackage

### rtl/wma_div.sv
module wma_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] mag_q, mag_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, mag_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      mag_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_d  = '0;
    end else if (busy_q) begin
      mag_d = {mag_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

### rtl/wma_datapath.sv
module wma_datapath #(
  parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [wma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [wma_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic signed [SAMPLE_BITS-1:0]        smoothed_o,
  input  wma_pkg::cmd_t                        cmd_i,
  output wma_pkg::status_t                     status_o
);

  import wma_pkg::*;

  localparam int WL_MAX  = (1 << WL_W) - 1;
  localparam int EFF_MAX = (MAX_WINDOW < WL_MAX) ? MAX_WINDOW : WL_MAX;
  localparam int W_W     = $clog2(EFF_MAX + 1);
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int CW      = (AW + 1 > W_W) ? AW + 1 : W_W;
  localparam int PROD_W  = SAMPLE_BITS + W_W + 1;
  localparam int ACC_W   = SAMPLE_BITS + 2 * W_W;
  localparam int DIV_W   = 2 * W_W;

  logic        [MODE_W-1:0]      mode_q;
  logic        [WL_W-1:0]        wl_q;
  logic        [W_W-1:0]         w;
  logic        [W_W-1:0]         wm1;
  logic                          tri_mode;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [SAMPLE_BITS-1:0] smoothed_q;

  logic        [AW-1:0]          cnt_q;
  logic        [AW-1:0]          wslot_q, wslot_d;
  logic        [AW-1:0]          slot;
  logic        [CW-1:0]          slot_inc;
  logic                          mem_we;
  logic        [AW-1:0]          mem_waddr;

  logic        [AW-1:0]          idx_q;
  logic        [W_W-1:0]         wt_q;
  logic                          v1_q, v2_q;
  logic        [W_W-1:0]         wt1_q, wt2_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic        [DIV_W-1:0]       dsum_q;

  logic                          div_done;
  logic signed [ACC_W-1:0]       quot;

  always_comb begin
    if (wl_q == '0) begin
      w = W_W'(1);
    end else if (int'(wl_q) > EFF_MAX) begin
      w = W_W'(EFF_MAX);
    end else begin
      w = W_W'(wl_q);
    end
  end

  assign wm1      = w - W_W'(1);
  assign tri_mode = mode_q == MODE_TRI;

  always_comb begin
    slot     = (CW'(wslot_q) >= CW'(w)) ? '0 : wslot_q;
    slot_inc = CW'(slot) + CW'(1);
    if (cmd_i.fill_done) begin
      wslot_d = (w == W_W'(1)) ? '0 : AW'(1);
    end else if (cmd_i.norm_write) begin
      wslot_d = (slot_inc >= CW'(w)) ? '0 : AW'(slot_inc);
    end else begin
      wslot_d = wslot_q;
    end
  end

  assign mem_we    = cmd_i.fill_write | cmd_i.norm_write;
  assign mem_waddr = cmd_i.fill_write ? cnt_q : slot;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= s_q;
    end
    if (cmd_i.walk_issue) begin
      rdata_q <= hist_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RECT;
      wl_q    <= WL_RESET;
      wslot_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MODE:   mode_q <= cfg_wdata_i[MODE_W-1:0];
          CFG_WINDOW: wl_q   <= cfg_wdata_i[WL_W-1:0];
          default:    ;
        endcase
      end
      wslot_q <= wslot_d;
      v1_q    <= cmd_i.walk_issue;
      v2_q    <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      s_q   <= sample_i;
      cnt_q <= '0;
    end else if (cmd_i.fill_write) begin
      cnt_q <= cnt_q + AW'(1);
    end

    if (cmd_i.fill_done || cmd_i.norm_write) begin
      idx_q  <= cmd_i.fill_done ? '0 : slot;
      wt_q   <= w;
      acc_q  <= '0;
      dsum_q <= '0;
    end else begin
      if (cmd_i.walk_issue) begin
        idx_q <= (idx_q == '0) ? AW'(wm1) : idx_q - AW'(1);
        wt_q  <= wt_q - W_W'(1);
      end
      if (v2_q) begin
        acc_q  <= acc_q + ACC_W'(prod_q);
        dsum_q <= dsum_q + DIV_W'(wt2_q);
      end
    end

    wt1_q  <= tri_mode ? wt_q : W_W'(1);
    prod_q <= PROD_W'($signed(rdata_q)) * PROD_W'($signed({1'b0, wt1_q}));
    wt2_q  <= wt1_q;

    if (cmd_i.load_out) begin
      smoothed_q <= status_o.pass ? s_q : SAMPLE_BITS'(quot);
    end
  end

  wma_div #(
    .NUM_W (ACC_W),
    .DEN_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (dsum_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign smoothed_o         = smoothed_q;
  assign status_o.fill_last = cnt_q == AW'(wm1);
  assign status_o.walk_last = wt_q == W_W'(1);
  assign status_o.pipe_busy = v1_q | v2_q;
  assign status_o.div_done  = div_done;
  assign status_o.pass      = (mode_q != MODE_RECT) && (mode_q != MODE_TRI);

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.div_start |-> !v1_q && !v2_q)
    else $error("division started with products still in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.walk_issue |-> wt_q != '0)
    else $error("history walk ran past the window");

endmodule

### rtl/wma_ctrl.sv
module wma_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wma_pkg::cmd_t    cmd_o,
  input  wma_pkg::status_t status_i
);

  import wma_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FILL   = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_DIVIDE = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   primed_q, primed_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = primed_q ? S_WRITE : S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_write = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.fill_done = 1'b1;
          primed_d        = 1'b1;
          state_d         = status_i.pass ? S_RESULT : S_WALK;
        end
      end
      S_WRITE: begin
        cmd_o.norm_write = 1'b1;
        state_d          = status_i.pass ? S_RESULT : S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_issue = 1'b1;
        if (status_i.walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(state_q == S_RESULT))
    else $error("result shown without a finished item");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == S_FILL |-> !primed_q)
    else $error("window filled twice");

endmodule

### rtl/windowed_moving_average.sv
// Channel  Valid        Stall         Payload
// input    in_valid_i   in_stall_o    sample_i
// output   out_valid_o  out_stall_i   smoothed_o
// config   cfg_we_i     -             cfg_index_i, cfg_wdata_i
//
// Mean modes handle each item with a walk of the single-port history memory
// and a one-bit-a-cycle divider over the accumulator (ACC_W bits, 30 at
// defaults). Pass-through skips the walk and the divider.
// The first item after reset also fills the window, writing its sample to every slot.
// Reset clears control state and configuration only; history is undefined until that fill.
// A result waiting behind out_stall_i holds the next item at its last step.
module windowed_moving_average #(
  parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [wma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [wma_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        smoothed_o
);

  import wma_pkg::*;

  cmd_t    cmd;
  status_t status;

  wma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  wma_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .smoothed_o  (smoothed_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
